@@ rtl/core/pnce_pkg.sv @@
// ----------------------------------------------------------------------------
// pnce_pkg
// Shared types, constants and helpers of the periodic neighbor cell enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package pnce_pkg;

    localparam int MAX_CELLS_PER_AXIS = 64;

    localparam int COORD_W    = 6;
    localparam int SIZE_W     = 7;
    localparam int CELL_W     = 18;
    localparam int YW_W       = 12;
    localparam int HZ_W       = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_2D = 2'd3;

    // effective grid geometry
    typedef struct packed {
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [SIZE_W-1:0] d;
        logic              flat;
    } t_geom;

    // sorted coordinates of one axis
    typedef struct packed {
        logic [1:0]               cnt;
        logic [2:0][COORD_W-1:0]  v;
    } t_axis;

    // front register stage
    typedef struct packed {
        logic                     invalid;
        logic [1:0]               cnt_x;
        logic [1:0]               cnt_y;
        logic [1:0]               cnt_z;
        logic [2:0][COORD_W-1:0]  xs;
        logic [2:0][COORD_W-1:0]  ys;
        logic [2:0][HZ_W-1:0]     hz;
    } t_s1;

    // classified item handed to the back unit
    typedef struct packed {
        logic                     invalid;
        logic [1:0]               cnt_x;
        logic [1:0]               cnt_y;
        logic [1:0]               cnt_z;
        logic [2:0][COORD_W-1:0]  xs;
        logic [2:0][YW_W-1:0]     yw;
        logic [2:0][CELL_W-1:0]   zwh;
    } t_desc;

    // wrapped neighbor coordinates of one axis in ascending order
    function automatic t_axis axis_sort(input logic [COORD_W-1:0] c,
                                        input logic [SIZE_W-1:0]  n,
                                        input logic               own_only);
        t_axis             a;
        logic [SIZE_W-1:0] c7;
        logic [SIZE_W-1:0] nm1;
        logic [SIZE_W-1:0] nm2;
        c7  = {1'b0, c};
        nm1 = n - 7'd1;
        nm2 = n - 7'd2;
        a   = '0;
        if (own_only || n == 7'd1) begin
            a.cnt  = 2'd1;
            a.v[0] = c;
        end else if (n == 7'd2) begin
            a.cnt  = 2'd2;
            a.v[0] = 6'd0;
            a.v[1] = 6'd1;
        end else begin
            a.cnt = 2'd3;
            if (c == 6'd0) begin
                a.v[0] = 6'd0;
                a.v[1] = 6'd1;
                a.v[2] = nm1[COORD_W-1:0];
            end else if (c7 == nm1) begin
                a.v[0] = 6'd0;
                a.v[1] = nm2[COORD_W-1:0];
                a.v[2] = nm1[COORD_W-1:0];
            end else begin
                a.v[0] = c - 6'd1;
                a.v[1] = c;
                a.v[2] = c + 6'd1;
            end
        end
        return a;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pnce_in_if.sv @@
// ----------------------------------------------------------------------------
// pnce_in_if
// Input channel: centre cell coordinates with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnce_in_if;
    logic                           valid;
    logic                           ready;
    logic [pnce_pkg::COORD_W-1:0]   coord_x;
    logic [pnce_pkg::COORD_W-1:0]   coord_y;
    logic [pnce_pkg::COORD_W-1:0]   coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/pnce_out_if.sv @@
// ----------------------------------------------------------------------------
// pnce_out_if
// Output channel: neighbor cell indices with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnce_out_if;
    logic                           valid;
    logic                           ready;
    logic [pnce_pkg::CELL_W-1:0]    neighbor_cell;
    logic                           is_last;
    logic                           invalid;

    modport source (output valid, output neighbor_cell, output is_last,
                    output invalid, input ready);
    modport sink   (input valid, input neighbor_cell, input is_last,
                    input invalid, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pnce_front.sv @@
// ----------------------------------------------------------------------------
// pnce_front
// Accepts a centre cell, checks it against the grid, builds the sorted axis
// lists and scales them into partial linear indices for the back unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pnce_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  pnce_pkg::t_geom         i_geom,
    pnce_in_if.sink                 in_ch,
    input  wire                     i_full,
    output logic                    o_push,
    output pnce_pkg::t_desc         o_desc
);

    logic              r_s1_valid;
    pnce_pkg::t_s1     r_s1;
    pnce_pkg::t_s1     n_s1;
    pnce_pkg::t_axis   ax_x;
    pnce_pkg::t_axis   ax_y;
    pnce_pkg::t_axis   ax_z;
    logic              bad;
    logic              accept;
    logic [pnce_pkg::SIZE_W+pnce_pkg::COORD_W-1:0]  hz_full [3];
    logic [pnce_pkg::SIZE_W+pnce_pkg::COORD_W-1:0]  yw_full [3];
    logic [pnce_pkg::SIZE_W+pnce_pkg::HZ_W-1:0]     zwh_full[3];

    assign in_ch.ready = !r_s1_valid || !i_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign o_push      = r_s1_valid && !i_full;

    // classify and take h * z
    always_comb begin
        bad  = ({1'b0, in_ch.coord_x} >= i_geom.w) ||
               ({1'b0, in_ch.coord_y} >= i_geom.h) ||
               ({1'b0, in_ch.coord_z} >= i_geom.d);
        ax_x = pnce_pkg::axis_sort(in_ch.coord_x, i_geom.w, 1'b0);
        ax_y = pnce_pkg::axis_sort(in_ch.coord_y, i_geom.h, 1'b0);
        ax_z = pnce_pkg::axis_sort(in_ch.coord_z, i_geom.d, i_geom.flat);
        n_s1 = '0;
        n_s1.invalid = bad;
        if (bad) begin
            n_s1.cnt_x = 2'd1;
            n_s1.cnt_y = 2'd1;
            n_s1.cnt_z = 2'd1;
        end else begin
            n_s1.cnt_x = ax_x.cnt;
            n_s1.cnt_y = ax_y.cnt;
            n_s1.cnt_z = ax_z.cnt;
            n_s1.xs    = ax_x.v;
            n_s1.ys    = ax_y.v;
        end
        for (int k = 0; k < 3; k++) begin
            hz_full[k] = (pnce_pkg::SIZE_W+pnce_pkg::COORD_W)'(i_geom.h) *
                         (pnce_pkg::SIZE_W+pnce_pkg::COORD_W)'(ax_z.v[k]);
            if (!bad) begin
                n_s1.hz[k] = hz_full[k][pnce_pkg::HZ_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // scale by the row width
    always_comb begin
        o_desc         = '0;
        o_desc.invalid = r_s1.invalid;
        o_desc.cnt_x   = r_s1.cnt_x;
        o_desc.cnt_y   = r_s1.cnt_y;
        o_desc.cnt_z   = r_s1.cnt_z;
        o_desc.xs      = r_s1.xs;
        for (int k = 0; k < 3; k++) begin
            yw_full[k]    = (pnce_pkg::SIZE_W+pnce_pkg::COORD_W)'(i_geom.w) *
                            (pnce_pkg::SIZE_W+pnce_pkg::COORD_W)'(r_s1.ys[k]);
            zwh_full[k]   = (pnce_pkg::SIZE_W+pnce_pkg::HZ_W)'(i_geom.w) *
                            (pnce_pkg::SIZE_W+pnce_pkg::HZ_W)'(r_s1.hz[k]);
            o_desc.yw[k]  = yw_full[k][pnce_pkg::YW_W-1:0];
            o_desc.zwh[k] = zwh_full[k][pnce_pkg::CELL_W-1:0];
        end
    end

    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1.invalid |->
            r_s1.cnt_x == 2'd1 && r_s1.cnt_y == 2'd1 && r_s1.cnt_z == 2'd1 &&
            r_s1.xs == '0 && r_s1.ys == '0 && r_s1.hz == '0)
        else $error("out-of-grid item carries neighbor data");

    a_held_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && i_full |=> r_s1_valid && $stable(r_s1))
        else $error("front stage lost an item while the queue was full");

endmodule

`default_nettype wire

@@ rtl/core/pnce_fifo.sv @@
// ----------------------------------------------------------------------------
// pnce_fifo
// Short queue of classified items between the front and the back unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pnce_fifo (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  pnce_pkg::t_desc         i_data,
    output logic                    o_full,
    input  wire                     i_pop,
    output pnce_pkg::t_desc         o_data,
    output logic                    o_empty
);

    pnce_pkg::t_desc                    r_mem [pnce_pkg::FIFO_DEPTH];
    logic [pnce_pkg::FIFO_PTR_W-1:0]    r_wr;
    logic [pnce_pkg::FIFO_PTR_W-1:0]    r_rd;
    logic [pnce_pkg::FIFO_CNT_W-1:0]    r_cnt;
    logic                               do_push;
    logic                               do_pop;

    assign o_full  = (r_cnt == pnce_pkg::FIFO_CNT_W'(pnce_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + pnce_pkg::FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - pnce_pkg::FIFO_CNT_W'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= pnce_pkg::FIFO_CNT_W'(pnce_pkg::FIFO_DEPTH))
        else $error("queue count past depth");

endmodule

`default_nettype wire

@@ rtl/core/pnce_back.sv @@
// ----------------------------------------------------------------------------
// pnce_back
// Walks the z, y, x neighbor lists of one item and sends one linear cell
// index per transfer through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pnce_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  pnce_pkg::t_desc         i_desc,
    input  wire                     i_empty,
    output logic                    o_pop,
    pnce_out_if.source              out_ch
);

    logic                           r_busy;
    pnce_pkg::t_desc                r_desc;
    logic [1:0]                     r_ix;
    logic [1:0]                     r_iy;
    logic [1:0]                     r_iz;
    logic                           r_out_valid;
    logic [pnce_pkg::CELL_W-1:0]    r_cell;
    logic                           r_last;
    logic                           r_inv;
    logic                           adv;
    logic                           end_x;
    logic                           end_y;
    logic                           end_z;
    logic                           at_last;
    logic [pnce_pkg::CELL_W-1:0]    sum;

    assign out_ch.valid         = r_out_valid;
    assign out_ch.neighbor_cell = r_cell;
    assign out_ch.is_last       = r_last;
    assign out_ch.invalid       = r_inv;

    always_comb begin
        adv     = r_busy && (!r_out_valid || out_ch.ready);
        end_x   = (r_ix == r_desc.cnt_x - 2'd1);
        end_y   = (r_iy == r_desc.cnt_y - 2'd1);
        end_z   = (r_iz == r_desc.cnt_z - 2'd1);
        at_last = end_x && end_y && end_z;
        o_pop   = !i_empty && (!r_busy || (adv && at_last));
        sum     = {{(pnce_pkg::CELL_W-pnce_pkg::COORD_W){1'b0}}, r_desc.xs[r_ix]} +
                  {{(pnce_pkg::CELL_W-pnce_pkg::YW_W){1'b0}}, r_desc.yw[r_iy]} +
                  r_desc.zwh[r_iz];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_ix        <= '0;
            r_iy        <= '0;
            r_iz        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_ix   <= '0;
                r_iy   <= '0;
                r_iz   <= '0;
            end else if (adv) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                end
                // x runs fastest, then y, then z
                if (end_x) begin
                    r_ix <= '0;
                    if (end_y) begin
                        r_iy <= '0;
                        r_iz <= r_iz + 2'd1;
                    end else begin
                        r_iy <= r_iy + 2'd1;
                    end
                end else begin
                    r_ix <= r_ix + 2'd1;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_desc <= i_desc;
        end
        if (adv) begin
            r_cell <= r_desc.invalid ? '0 : sum;
            r_last <= at_last;
            r_inv  <= r_desc.invalid;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_ix < r_desc.cnt_x && r_iy < r_desc.cnt_y && r_iz < r_desc.cnt_z)
        else $error("neighbor walk ran past its list");

    a_invalid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_inv |-> r_last && r_cell == '0)
        else $error("out-of-grid result is not a single zero entry");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_busy || (adv && at_last))
        else $error("new item taken while the walk is unfinished");

endmodule

`default_nettype wire

@@ rtl/core/periodic_neighbor_cell_enumerator.sv @@
// ----------------------------------------------------------------------------
// periodic_neighbor_cell_enumerator
// Emits the sorted linear indices of the neighbor cells of one grid cell.
// ----------------------------------------------------------------------------
// Each accepted cell yields between 1 and 27 results (nx * ny * nz, each axis
// contributing 1 to 3 wrapped coordinates), one result per clock while the
// output is not stalled, through the back unit's single index adder, so the
// sustained input rate is bounded by the result count of each item. From
// input transfer to first result an item passes the front register, the
// queue, the back walk and the output register. Out-of-grid cells give one
// result with invalid and is_last set. Axis sizes of 0 act as 1 and sizes
// above 64 act as 64. Registers: 0 cells_x, 1 cells_y, 2 cells_z, 3 flat_2d;
// write them only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_neighbor_cell_enumerator (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    pnce_in_if.sink                             in_ch,
    pnce_out_if.source                          out_ch,
    input  wire                                 i_cfg_we,
    input  wire [pnce_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [pnce_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [pnce_pkg::SIZE_W-1:0]    r_cells_x;
    logic [pnce_pkg::SIZE_W-1:0]    r_cells_y;
    logic [pnce_pkg::SIZE_W-1:0]    r_cells_z;
    logic                           r_flat_2d;
    pnce_pkg::t_geom                geom;
    pnce_pkg::t_desc                push_desc;
    pnce_pkg::t_desc                pop_desc;
    logic                           push;
    logic                           pop;
    logic                           full;
    logic                           empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= 7'd1;
            r_cells_y <= 7'd1;
            r_cells_z <= 7'd1;
            r_flat_2d <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pnce_pkg::CFG_CELLS_X: begin
                    r_cells_x <= i_cfg_data;
                end
                pnce_pkg::CFG_CELLS_Y: begin
                    r_cells_y <= i_cfg_data;
                end
                pnce_pkg::CFG_CELLS_Z: begin
                    r_cells_z <= i_cfg_data;
                end
                pnce_pkg::CFG_FLAT_2D: begin
                    r_flat_2d <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    function automatic logic [pnce_pkg::SIZE_W-1:0] eff_size(
            input logic [pnce_pkg::SIZE_W-1:0] v);
        logic [pnce_pkg::SIZE_W-1:0] r;
        if (v == '0) begin
            r = 7'd1;
        end else if (v > pnce_pkg::SIZE_W'(pnce_pkg::MAX_CELLS_PER_AXIS)) begin
            r = pnce_pkg::SIZE_W'(pnce_pkg::MAX_CELLS_PER_AXIS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_comb begin
        geom.w    = eff_size(r_cells_x);
        geom.h    = eff_size(r_cells_y);
        geom.d    = eff_size(r_cells_z);
        geom.flat = r_flat_2d;
    end

    pnce_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .in_ch   (in_ch),
        .i_full  (full),
        .o_push  (push),
        .o_desc  (push_desc)
    );

    pnce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_desc),
        .o_empty (empty)
    );

    pnce_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (pop_desc),
        .i_empty (empty),
        .o_pop   (pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

@@ verif/periodic_neighbor_cell_enumerator_test.sv @@
// ----------------------------------------------------------------------------
// periodic_neighbor_cell_enumerator_test
// Drives centre cells into the enumerator under a series of grid settings.
// Each result is checked against a local model of the wrapped 3x3x3
// neighborhood, or, for the fixed rows of the stimulus table, against fixed values.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_neighbor_cell_enumerator_test;

    typedef struct packed {
        logic [pnce_pkg::CELL_W-1:0] nb_index;
        logic                        last;
        logic                        invalid;
    } t_cell_result;

    typedef enum logic [1:0] {ROW_CFG, ROW_CELL, ROW_CELL_FIXED} t_row_kind;

    typedef struct {
        t_row_kind                         kind;
        logic [pnce_pkg::CFG_IDX_W-1:0]    reg_idx;
        logic [pnce_pkg::CFG_DATA_W-1:0]   reg_data;
        logic [pnce_pkg::COORD_W-1:0]      x;
        logic [pnce_pkg::COORD_W-1:0]      y;
        logic [pnce_pkg::COORD_W-1:0]      z;
        logic [pnce_pkg::CELL_W-1:0]       nb_index;
        logic                              last;
        logic                              invalid;
    } t_stim_row;

    localparam int NUM_ROWS     = 35;
    localparam int NUM_BLOCKS   = 12;
    localparam int BLOCK_ITEMS  = 30;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [pnce_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [pnce_pkg::CFG_DATA_W-1:0] i_cfg_data;

    pnce_in_if  coord_ch ();
    pnce_out_if neighbor_ch ();

    periodic_neighbor_cell_enumerator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (coord_ch),
        .out_ch      (neighbor_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the grid registers
    logic [pnce_pkg::SIZE_W-1:0] grid_x;
    logic [pnce_pkg::SIZE_W-1:0] grid_y;
    logic [pnce_pkg::SIZE_W-1:0] grid_z;
    logic                        flat_layer;

    t_cell_result pending_cells [$];
    int           mismatch_count = 0;
    int           send_idle_pct = 17;
    int           recv_idle_pct = 65;
    int           hold_requests = 0;
    int           hold_served = 0;

    t_stim_row directed_rows [0:NUM_ROWS-1] = '{
        // 1x1x1 grid after reset
        '{ROW_CELL_FIXED, '0, '0, 6'd0, 6'd0, 6'd0, 18'd0, 1'b1, 1'b0},
        '{ROW_CELL_FIXED, '0, '0, 6'd1, 6'd0, 6'd0, 18'd0, 1'b1, 1'b1},
        '{ROW_CELL_FIXED, '0, '0, 6'd63, 6'd63, 6'd63, 18'd0, 1'b1, 1'b1},
        // zero size acts as one
        '{ROW_CFG, pnce_pkg::CFG_CELLS_X, 7'd0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_CELLS_Y, 7'd2, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_CELLS_Z, 7'd3, '0, '0, '0, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd0, 6'd0, 6'd0, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd0, 6'd1, 6'd2, '0, '0, '0},
        '{ROW_CELL_FIXED, '0, '0, 6'd0, 6'd2, 6'd0, 18'd0, 1'b1, 1'b1},
        // full grid, oversize x saturates
        '{ROW_CFG, pnce_pkg::CFG_CELLS_X, 7'd127, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_CELLS_Y, 7'd64, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_CELLS_Z, 7'd64, '0, '0, '0, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd0, 6'd0, 6'd0, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd63, 6'd63, 6'd63, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd31, 6'd0, 6'd63, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_FLAT_2D, 7'd1, '0, '0, '0, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd63, 6'd63, 6'd63, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd5, 6'd5, 6'd0, '0, '0, '0},
        // flat mode still range-checks z
        '{ROW_CFG, pnce_pkg::CFG_CELLS_X, 7'd3, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_CELLS_Y, 7'd3, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_CELLS_Z, 7'd2, '0, '0, '0, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd0, 6'd0, 6'd1, '0, '0, '0},
        '{ROW_CELL_FIXED, '0, '0, 6'd2, 6'd2, 6'd2, 18'd0, 1'b1, 1'b1},
        '{ROW_CELL, '0, '0, 6'd1, 6'd1, 6'd0, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_FLAT_2D, 7'd0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_CELLS_Z, 7'd0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_CELLS_Y, 7'd1, '0, '0, '0, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd1, 6'd0, 6'd0, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd2, 6'd0, 6'd0, '0, '0, '0},
        '{ROW_CELL_FIXED, '0, '0, 6'd0, 6'd0, 6'd1, 18'd0, 1'b1, 1'b1},
        // two-cell axes give no lower neighbor
        '{ROW_CFG, pnce_pkg::CFG_CELLS_X, 7'd2, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_CELLS_Y, 7'd3, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, pnce_pkg::CFG_CELLS_Z, 7'd2, '0, '0, '0, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd1, 6'd2, 6'd1, '0, '0, '0},
        '{ROW_CELL, '0, '0, 6'd0, 6'd0, 6'd0, '0, '0, '0}
    };

    function automatic void add_expected(input t_cell_result r);
        pending_cells.insert(pending_cells.size(), r);
    endfunction

    function automatic int unsigned axis_size(input logic [pnce_pkg::SIZE_W-1:0] reg_val);
        if (reg_val == '0) return 1;
        if (reg_val > pnce_pkg::SIZE_W'(pnce_pkg::MAX_CELLS_PER_AXIS)) begin
            return pnce_pkg::MAX_CELLS_PER_AXIS;
        end
        return 32'(reg_val);
    endfunction

    // wrapped coordinates of one axis, ascending
    function automatic void axis_span(input int unsigned c, input int unsigned n,
                                      input bit own_only,
                                      output int unsigned vals [3], output int cnt);
        int unsigned t;
        vals[0] = c;
        vals[1] = 0;
        vals[2] = 0;
        cnt     = 1;
        if (!own_only && n >= 3) begin
            vals[cnt] = (c + n - 1) % n;
            cnt++;
        end
        if (!own_only && n >= 2) begin
            vals[cnt] = (c + 1) % n;
            cnt++;
        end
        for (int a = 1; a < cnt; a++) begin
            for (int b = a; b > 0; b--) begin
                if (vals[b-1] > vals[b]) begin
                    t         = vals[b];
                    vals[b]   = vals[b-1];
                    vals[b-1] = t;
                end
            end
        end
    endfunction

    function automatic void predict_neighbors(input logic [pnce_pkg::COORD_W-1:0] cx,
                                              input logic [pnce_pkg::COORD_W-1:0] cy,
                                              input logic [pnce_pkg::COORD_W-1:0] cz);
        int unsigned  w, h, d, lin;
        int unsigned  xs [3];
        int unsigned  ys [3];
        int unsigned  zs [3];
        int           nx, ny, nz, total, n;
        t_cell_result r;
        w = axis_size(grid_x);
        h = axis_size(grid_y);
        d = axis_size(grid_z);
        if (cx >= w || cy >= h || cz >= d) begin
            r.nb_index = '0;
            r.last     = 1'b1;
            r.invalid  = 1'b1;
            add_expected(r);
            return;
        end
        axis_span(cx, w, 1'b0, xs, nx);
        axis_span(cy, h, 1'b0, ys, ny);
        axis_span(cz, d, flat_layer, zs, nz);
        total = nx * ny * nz;
        n     = 0;
        for (int iz = 0; iz < nz; iz++) begin
            for (int iy = 0; iy < ny; iy++) begin
                for (int ix = 0; ix < nx; ix++) begin
                    lin        = xs[ix] + w * (ys[iy] + h * zs[iz]);
                    r.nb_index = lin[pnce_pkg::CELL_W-1:0];
                    r.last     = (n == total - 1);
                    r.invalid  = 1'b0;
                    add_expected(r);
                    n++;
                end
            end
        end
    endfunction

    function automatic logic [pnce_pkg::SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(9);
        case (r)
            0: return '0;
            1: return pnce_pkg::SIZE_W'($urandom_range(127,
                                            pnce_pkg::MAX_CELLS_PER_AXIS + 1));
            2: return pnce_pkg::SIZE_W'(pnce_pkg::MAX_CELLS_PER_AXIS);
            3: return pnce_pkg::SIZE_W'($urandom_range(pnce_pkg::MAX_CELLS_PER_AXIS - 1,
                                                       7));
            default: return pnce_pkg::SIZE_W'($urandom_range(6, 1));
        endcase
    endfunction

    // mostly in-grid, biased to the wrap edges, with some arbitrary values
    function automatic logic [pnce_pkg::COORD_W-1:0] pick_coord(input int unsigned n);
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0) return pnce_pkg::COORD_W'($urandom_range((1 << pnce_pkg::COORD_W) - 1));
        if (r == 1) return '0;
        if (r == 2) return pnce_pkg::COORD_W'(n - 1);
        return pnce_pkg::COORD_W'($urandom_range(n - 1, 0));
    endfunction

    task automatic write_cfg(input logic [pnce_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pnce_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            pnce_pkg::CFG_CELLS_X: grid_x = data;
            pnce_pkg::CFG_CELLS_Y: grid_y = data;
            pnce_pkg::CFG_CELLS_Z: grid_z = data;
            pnce_pkg::CFG_FLAT_2D: flat_layer = data[0];
            default: ;
        endcase
    endtask

    // stop offering and let every pending result drain
    task automatic wait_idle();
        coord_ch.valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_cell(input logic [pnce_pkg::COORD_W-1:0] x,
                             input logic [pnce_pkg::COORD_W-1:0] y,
                             input logic [pnce_pkg::COORD_W-1:0] z, input bit fixed,
                             input t_cell_result fixed_res);
        while ($urandom_range(99) < send_idle_pct) begin
            coord_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        coord_ch.valid   <= 1'b1;
        coord_ch.coord_x <= x;
        coord_ch.coord_y <= y;
        coord_ch.coord_z <= z;
        do @(posedge i_clk); while (!coord_ch.ready);
        if (fixed) add_expected(fixed_res);
        else predict_neighbors(x, y, z);
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        neighbor_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                neighbor_ch.ready <= 1'b0;
            end else begin
                neighbor_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && neighbor_ch.valid && neighbor_ch.ready) begin
            if (pending_cells.size() == 0) begin
                $error("result with nothing pending: neighbor_cell=%0d",
                       neighbor_ch.neighbor_cell);
                mismatch_count++;
            end else begin
                want = pending_cells.pop_front();
                if (neighbor_ch.neighbor_cell !== want.nb_index) begin
                    $error("neighbor_cell: expected %0d, got %0d", want.nb_index,
                           neighbor_ch.neighbor_cell);
                    mismatch_count++;
                end
                if (neighbor_ch.is_last !== want.last) begin
                    $error("is_last: expected %0b, got %0b", want.last, neighbor_ch.is_last);
                    mismatch_count++;
                end
                if (neighbor_ch.invalid !== want.invalid) begin
                    $error("invalid: expected %0b, got %0b", want.invalid, neighbor_ch.invalid);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        bit           cfg_open;
        t_cell_result fixed_res;
        int unsigned  w, h, d;
        cfg_open = 1'b0;
        grid_x     = 7'd1;
        grid_y     = 7'd1;
        grid_z     = 7'd1;
        flat_layer = 1'b0;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        coord_ch.valid   <= 1'b0;
        coord_ch.coord_x <= '0;
        coord_ch.coord_y <= '0;
        coord_ch.coord_z <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                if (!cfg_open) begin
                    wait_idle();
                    cfg_open = 1'b1;
                end
                write_cfg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                fixed_res.nb_index = directed_rows[i].nb_index;
                fixed_res.last     = directed_rows[i].last;
                fixed_res.invalid  = directed_rows[i].invalid;
                push_cell(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                          directed_rows[i].kind == ROW_CELL_FIXED, fixed_res);
            end
        end

        for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
            if (blk < 4) begin
                send_idle_pct = 17;
                recv_idle_pct = 65;
            end else if (blk < 8) begin
                send_idle_pct = 65;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            write_cfg(pnce_pkg::CFG_CELLS_X, pick_size());
            write_cfg(pnce_pkg::CFG_CELLS_Y, pick_size());
            write_cfg(pnce_pkg::CFG_CELLS_Z, pick_size());
            write_cfg(pnce_pkg::CFG_FLAT_2D, pnce_pkg::CFG_DATA_W'($urandom_range(1)));
            i_cfg_we <= 1'b0;
            w = axis_size(grid_x);
            h = axis_size(grid_y);
            d = axis_size(grid_z);
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                // output stalled for a long stretch while input keeps coming
                if (blk == 8 && k == 0) hold_requests++;
                if (blk == 5 && k == 15) wait_idle();
                push_cell(pick_coord(w), pick_coord(h), pick_coord(d), 1'b0, fixed_res);
            end
        end

        coord_ch.valid <= 1'b0;
        for (int n = 0; n < 20000 && pending_cells.size() != 0; n++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_cells.size() != 0) begin
            $error("%0d expected results never arrived", pending_cells.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ periodic_neighbor_cell_enumerator.f @@
rtl/core/pnce_pkg.sv
rtl/core/pnce_in_if.sv
rtl/core/pnce_out_if.sv
rtl/core/pnce_front.sv
rtl/core/pnce_fifo.sv
rtl/core/pnce_back.sv
rtl/core/periodic_neighbor_cell_enumerator.sv
verif/periodic_neighbor_cell_enumerator_test.sv
